/* rtl/tkr_pkg.sv */
// Package: keyword table, type codes and character helpers for the type keyword recogniser
`default_nettype none

package tkr_pkg;

    // Name position counter and limits
    localparam int POS_W        = 6;
    localparam int MAX_NAME_LEN = 32;
    localparam int KW_COUNT     = 27;
    localparam int KW_ROOM      = 18;
    localparam int KW_TEXT_W    = 8 * KW_ROOM;

    typedef logic [7:0]          t_char;
    typedef logic [KW_COUNT-1:0] t_kw_mask;

    // Type codes as given on the result channel
    typedef enum logic [3:0] {
        TYPE_UNDEF   = 4'd0,
        TYPE_U8      = 4'd1,
        TYPE_U16     = 4'd2,
        TYPE_U32     = 4'd3,
        TYPE_U64     = 4'd4,
        TYPE_S8      = 4'd5,
        TYPE_S16     = 4'd6,
        TYPE_S32     = 4'd7,
        TYPE_S64     = 4'd8,
        TYPE_FLOAT   = 4'd9,
        TYPE_DOUBLE  = 4'd10,
        TYPE_WRAPPER = 4'd11
    } t_type_code;

    // Keyword text, right aligned: the first character sits in the highest used byte
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        KW_TEXT_W'("u8"), KW_TEXT_W'("u16"), KW_TEXT_W'("u32"), KW_TEXT_W'("u64"),
        KW_TEXT_W'("s8"), KW_TEXT_W'("s16"), KW_TEXT_W'("s32"), KW_TEXT_W'("s64"),
        KW_TEXT_W'("float"), KW_TEXT_W'("double"),
        KW_TEXT_W'({"unsigned", "_8"}), KW_TEXT_W'({"unsigned", "_16"}),
        KW_TEXT_W'({"unsigned", "_32"}), KW_TEXT_W'({"unsigned", "_64"}),
        KW_TEXT_W'({"signed", "_8"}), KW_TEXT_W'({"signed", "_16"}),
        KW_TEXT_W'({"signed", "_32"}), KW_TEXT_W'({"signed", "_64"}),
        KW_TEXT_W'("unsigned_byte"), KW_TEXT_W'("signed_byte"),
        KW_TEXT_W'("unsigned_int"), KW_TEXT_W'("signed_int"),
        KW_TEXT_W'("unsigned_long_long"), KW_TEXT_W'("signed_long_long"),
        KW_TEXT_W'({"byte", "_wrapper"}), KW_TEXT_W'("bytewrapper"),
        KW_TEXT_W'("wrapper")
    };

    localparam int KW_LEN [KW_COUNT] = '{
        2, 3, 3, 3, 2, 3, 3, 3, 5, 6,
        10, 11, 11, 11, 8, 9, 9, 9,
        13, 11, 12, 10, 18, 16, 12, 11, 7
    };

    localparam t_type_code KW_CODE [KW_COUNT] = '{
        TYPE_U8, TYPE_U16, TYPE_U32, TYPE_U64,
        TYPE_S8, TYPE_S16, TYPE_S32, TYPE_S64,
        TYPE_FLOAT, TYPE_DOUBLE,
        TYPE_U8, TYPE_U16, TYPE_U32, TYPE_U64,
        TYPE_S8, TYPE_S16, TYPE_S32, TYPE_S64,
        TYPE_U8, TYPE_S8, TYPE_U32, TYPE_S32,
        TYPE_U64, TYPE_S64,
        TYPE_WRAPPER, TYPE_WRAPPER, TYPE_WRAPPER
    };

    // Fold upper case to lower case, space to underscore
    function automatic t_char normalise_char(input t_char c);
        t_char r;
        r = c;
        if (c >= "A" && c <= "Z") begin
            r = c + 8'd32;
        end else if (c == " ") begin
            r = "_";
        end
        return r;
    endfunction

    // Byte size of a type code; wrapper and undefined have none
    function automatic logic [3:0] size_of_code(input t_type_code code);
        logic [3:0] s;
        unique case (code)
            TYPE_U8, TYPE_S8:                            s = 4'd1;
            TYPE_U16, TYPE_S16:                          s = 4'd2;
            TYPE_U32, TYPE_S32, TYPE_FLOAT:              s = 4'd4;
            TYPE_U64, TYPE_S64, TYPE_DOUBLE:             s = 4'd8;
            default:                                     s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/tkr_match.sv */
// Parallel keyword comparator: narrows the live keyword set and picks the matching code
`default_nettype none

module tkr_match
    import tkr_pkg::*;
(
    input  wire t_char                  i_char,
    input  wire logic [POS_W-1:0]       i_pos,
    input  wire t_kw_mask               i_alive,
    output t_kw_mask                    o_alive,
    output t_type_code                  o_code
);

    t_char norm_char;

    assign norm_char = normalise_char(i_char);

    // One compare per keyword against the byte at the current position
    always_comb begin
        int   sh;
        logic keep;
        o_alive = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            keep = 1'b0;
            for (int i = 0; i < KW_ROOM; i++) begin
                sh = (i < KW_LEN[k]) ? (KW_LEN[k] - 1 - i) : 0;
                if (i < KW_LEN[k] && i_pos == POS_W'(i) &&
                    KW_TEXT[k][8*sh +: 8] == norm_char) begin
                    keep = 1'b1;
                end
            end
            o_alive[k] = i_alive[k] & keep;
        end
    end

    // Keyword complete at this length; the later table entry wins
    always_comb begin
        o_code = TYPE_UNDEF;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (o_alive[k] &&
                ((POS_W+1)'(i_pos) + (POS_W+1)'(1)) == (POS_W+1)'(KW_LEN[k])) begin
                o_code = KW_CODE[k];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/type_keyword_recognizer.sv */
// Top level: type name recogniser with input register, matcher state and result register
//
// Usage:
//   Slave channel takes one character of a type name per transaction on
//   i_s_tdata; i_s_tlast marks the final character of the name. Each
//   character is folded (upper to lower case, space to underscore) and
//   compared against all 27 type keywords at once.
//   Master channel gives one transaction per name, after its last
//   character: type code and byte size. Unknown names, proper prefixes
//   and names longer than 32 characters give code 0, size 0.
//   The result of a last character reaches the master side through the
//   input register, then the result register.
//   Throughput: one character per cycle unless a last character waits for
//   the result register, set by the combinational compare stage between the two registers.
//   Reset clears both pipeline valids and the name state, so the next
//   character starts a fresh name.
//   When the receiver stalls, the result register holds; characters that
//   are not last keep flowing, and a last character waits in the input
//   register until the result register is free.
`default_nettype none

module type_keyword_recognizer
    import tkr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Slave channel
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] name_char
    input  wire logic       i_s_tlast,   // name_end
    // Master channel
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata    // [3:0] type_code, [7:4] size_bytes
);

    // Input register
    logic             r_in_valid;
    t_char            r_char;
    logic             r_end;

    // Name state
    logic [POS_W-1:0] r_pos,      n_pos;
    t_kw_mask         r_alive,    n_alive;
    logic             r_too_long, n_too_long;

    // Result register
    logic             r_out_valid;
    t_type_code       r_code;
    logic [3:0]       r_size;

    t_kw_mask         match_alive;
    t_type_code       match_code;
    t_type_code       res_code;
    logic             pos_full;
    logic             out_free;
    logic             advance;

    tkr_match u_match (
        .i_char  (r_char),
        .i_pos   (r_pos),
        .i_alive (r_alive),
        .o_alive (match_alive),
        .o_code  (match_code)
    );

    // Handshake control
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!r_end || out_free);
    assign o_s_tready = !r_in_valid || advance;
    assign pos_full   = r_pos >= POS_W'(MAX_NAME_LEN);

    // Next name state and result
    always_comb begin
        n_too_long = r_too_long | pos_full;
        n_alive    = pos_full ? r_alive : match_alive;
        n_pos      = r_pos;
        res_code   = n_too_long ? TYPE_UNDEF : match_code;
        if (r_end) begin
            n_pos      = '0;
            n_alive    = '1;
            n_too_long = 1'b0;
        end else if (!n_too_long && !pos_full) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready) begin
            r_char <= i_s_tdata;
            r_end  <= i_s_tlast;
        end
    end

    // Name state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_alive    <= '1;
            r_too_long <= 1'b0;
        end else if (advance) begin
            r_pos      <= n_pos;
            r_alive    <= n_alive;
            r_too_long <= n_too_long;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_end) begin
            r_code <= res_code;
            r_size <= size_of_code(res_code);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_size, r_code};

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench for the type keyword recogniser: streamed names, predicted type codes and sizes
module testbench;
    import tkr_pkg::*;

    localparam int NAME_LIMIT  = MAX_NAME_LEN;
    localparam int QUIET_LIMIT = 2000;

    // One character on the slave channel, or a marker that waits for all results
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       drain;
    } t_stim_item;

    typedef struct {
        t_type_code code;
        logic [3:0] size;
    } t_type_result;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;   // [7:0] name_char
    logic       i_s_tlast  = 1'b0;    // name_end
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;            // [3:0] type_code, [7:4] size_bytes

    // Known type names after folding, with their codes
    string kw_text [27] = '{
        "u8", "u16", "u32", "u64", "s8", "s16", "s32", "s64", "float", "double",
        {"unsigned", "_8"}, {"unsigned", "_16"}, {"unsigned", "_32"}, {"unsigned", "_64"},
        {"signed", "_8"}, {"signed", "_16"}, {"signed", "_32"}, {"signed", "_64"},
        "unsigned_byte", "signed_byte", "unsigned_int", "signed_int",
        "unsigned_long_long", "signed_long_long",
        {"byte", "_wrapper"}, "bytewrapper", "wrapper"
    };
    t_type_code kw_type [27] = '{
        TYPE_U8, TYPE_U16, TYPE_U32, TYPE_U64, TYPE_S8, TYPE_S16, TYPE_S32, TYPE_S64,
        TYPE_FLOAT, TYPE_DOUBLE,
        TYPE_U8, TYPE_U16, TYPE_U32, TYPE_U64, TYPE_S8, TYPE_S16, TYPE_S32, TYPE_S64,
        TYPE_U8, TYPE_S8, TYPE_U32, TYPE_S32, TYPE_U64, TYPE_S64,
        TYPE_WRAPPER, TYPE_WRAPPER, TYPE_WRAPPER
    };

    // Name tracking state
    int          name_pos      = 0;
    logic [26:0] kw_alive      = '1;
    logic        name_overlong = 1'b0;

    t_stim_item   stim_q[$];
    t_type_result type_expect_q[$];
    logic [7:0]   name_buf[$];

    int chars_sent   = 0;
    int fail_count   = 0;
    int quiet_cycles = 0;
    int cycle_no     = 0;

    type_keyword_recognizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [3:0] bytes_of_type(input t_type_code t);
        case (t)
            TYPE_U8, TYPE_S8:                return 4'd1;
            TYPE_U16, TYPE_S16:              return 4'd2;
            TYPE_U32, TYPE_S32:              return 4'd4;
            TYPE_FLOAT:                      return 4'd4;
            TYPE_U64, TYPE_S64, TYPE_DOUBLE: return 4'd8;
            default:                         return 4'd0;
        endcase
    endfunction

    // Advance the name state by one accepted character; a last character queues a result
    function automatic void take_name_char(input logic [7:0] raw, input logic last);
        logic [7:0]   c;
        t_type_code   found;
        t_type_result res;
        c = raw;
        if (raw >= "A" && raw <= "Z") begin
            c = raw + 8'd32;
        end else if (raw == " ") begin
            c = "_";
        end
        if (name_pos >= NAME_LIMIT) begin
            name_overlong = 1'b1;
        end else begin
            for (int k = 0; k < 27; k++) begin
                if (!(name_pos < kw_text[k].len() && kw_text[k][name_pos] == c)) begin
                    kw_alive[k] = 1'b0;
                end
            end
        end
        if (!last) begin
            if (!name_overlong && name_pos < NAME_LIMIT) begin
                name_pos++;
            end
        end else begin
            found = TYPE_UNDEF;
            if (!name_overlong) begin
                for (int k = 0; k < 27; k++) begin
                    if (kw_alive[k] && kw_text[k].len() == name_pos + 1) begin
                        found = kw_type[k];
                    end
                end
            end
            res.code = found;
            res.size = bytes_of_type(found);
            type_expect_q.push_back(res);
            name_pos      = 0;
            kw_alive      = '1;
            name_overlong = 1'b0;
        end
    endfunction

    // Append text to the name being built; optionally scramble case and underscores
    function automatic void put_text(input string s, input bit mangle);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mangle && c >= "a" && c <= "z" && $urandom_range(0, 1)) begin
                c = c - 8'd32;
            end else if (mangle && c == "_" && $urandom_range(0, 1)) begin
                c = " ";
            end
            name_buf.push_back(c);
        end
    endfunction

    // Move the built name into the stimulus queue, last flag on its final character
    function automatic void close_name();
        t_stim_item it;
        for (int i = 0; i < name_buf.size(); i++) begin
            it.ch    = name_buf[i];
            it.last  = (i == name_buf.size() - 1);
            it.drain = 1'b0;
            stim_q.push_back(it);
        end
        name_buf.delete();
    endfunction

    // Sender: offers queued characters, holds while stalled, idles at random
    always @(posedge i_clk) begin
        t_stim_item nxt;
        logic       offer;
        if (i_s_tvalid && o_s_tready) begin
            take_name_char(i_s_tdata, i_s_tlast);
            chars_sent++;
        end
        if (!i_rst_n) begin
            offer = 1'b0;
        end else if (i_s_tvalid && !o_s_tready) begin
            offer = 1'b1;
        end else begin
            offer = 1'b0;
            if (stim_q.size() != 0) begin
                if (stim_q[0].drain) begin
                    if (type_expect_q.size() == 0) begin
                        void'(stim_q.pop_front());
                    end
                end else if ((chars_sent >= 150 && chars_sent < 300) ||
                             $urandom_range(0, 99) >= 30) begin
                    nxt = stim_q.pop_front();
                    offer = 1'b1;
                    i_s_tdata <= nxt.ch;
                    i_s_tlast <= nxt.last;
                end
            end
        end
        i_s_tvalid <= offer;
    end

    // Receiver ready: one long hold-off, one stretch always ready, random otherwise
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= 300 && cycle_no < 420) begin
            i_m_tready <= 1'b0;
        end else if (cycle_no >= 500 && cycle_no < 800) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= 30);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_type_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (type_expect_q.size() == 0) begin
                $error("unexpected result transaction, tdata %h", o_m_tdata);
                fail_count++;
            end else begin
                want = type_expect_q.pop_front();
                if (o_m_tdata[3:0] !== want.code) begin
                    $error("type_code: expected %0d, got %0d", want.code, o_m_tdata[3:0]);
                    fail_count++;
                end
                if (o_m_tdata[7:4] !== want.size) begin
                    $error("size_bytes: expected %0d, got %0d", want.size, o_m_tdata[7:4]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int  k;
        int  n;
        int  r;
        bit  mid_drain_done;
        mid_drain_done = 0;

        // Directed names: case folding, space, zero and all-ones bytes, prefix, wrapper
        put_text("U8", 0);           close_name();
        name_buf.push_back(8'h00);   close_name();
        name_buf.push_back(8'hFF);   close_name();
        put_text("u", 0);            close_name();
        put_text("Signed 8", 0);     close_name();
        put_text("byte wrapper", 0); close_name();
        stim_q.push_back('{ch: 8'h00, last: 1'b0, drain: 1'b1});

        // Random names, mostly real keywords with scrambled case
        while (stim_q.size() < 575) begin
            k = $urandom_range(0, 26);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                put_text(kw_text[k], 1);
            end else if (r < 65) begin
                n = $urandom_range(1, kw_text[k].len() - 1);
                put_text(kw_text[k].substr(0, n - 1), 1);
            end else if (r < 72) begin
                put_text(kw_text[k], 1);
                name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (r < 78) begin
                put_text(kw_text[k], 1);
                name_buf.push_back(8'($urandom_range(0, 255)));
            end else if (r < 90) begin
                n = $urandom_range(1, 6);
                repeat (n) name_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                // over-long name, lengths either side of the limit
                n = $urandom_range(30, 70);
                put_text(kw_text[k], 1);
                while (name_buf.size() < n) name_buf.push_back(8'($urandom_range(0, 255)));
            end
            close_name();
            if (!mid_drain_done && stim_q.size() >= 400) begin
                stim_q.push_back('{ch: 8'h00, last: 1'b0, drain: 1'b1});
                mid_drain_done = 1;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(stim_q.size() == 0 && !i_s_tvalid && type_expect_q.size() == 0) &&
               quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        if (quiet_cycles < QUIET_LIMIT) begin
            repeat (6) @(posedge i_clk);
        end
        if (fail_count == 0 && quiet_cycles < QUIET_LIMIT && type_expect_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/tkr_pkg.sv
rtl/tkr_match.sv
rtl/type_keyword_recognizer.sv
tb/testbench.sv
